>>> src/lfr_pkg.sv
package lfr_pkg;

  localparam logic [1:0] KIND_HSI   = 2'd0;
  localparam logic [1:0] KIND_RGBW  = 2'd1;
  localparam logic [1:0] KIND_IDENT = 2'd2;

  localparam logic [7:0] CRC_INIT = 8'hff;
  localparam logic [7:0] CRC_POLY = 8'h31;

  localparam int OUT_TDATA_W = 40;

  typedef struct packed {
    logic [7:0] device_address;
    logic [7:0] broadcast_address;
    logic [7:0] start_byte;
    logic [7:0] confirm_byte;
    logic [7:0] escape_byte;
    logic [7:0] cmd_code_hsi;
    logic [7:0] cmd_code_rgbw;
    logic [7:0] cmd_code_ident;
  } cfg_t;

  typedef struct packed {
    logic [7:0] value_d;
    logic [7:0] value_c;
    logic [7:0] value_b;
    logic [7:0] value_a;
    logic [1:0] command_kind;
  } result_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] crc;
    crc = crc_in ^ data;
    for (int b = 0; b < 8; b++) begin
      if (crc[7]) begin
        crc = {crc[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc = {crc[6:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

>>> src/lfr_cfg.sv
module lfr_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [4:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready,
  output lfr_pkg::cfg_t       cfg
);

  localparam logic [2:0] REG_DEV     = 3'd0;
  localparam logic [2:0] REG_BCAST   = 3'd1;
  localparam logic [2:0] REG_START   = 3'd2;
  localparam logic [2:0] REG_CONFIRM = 3'd3;
  localparam logic [2:0] REG_ESCAPE  = 3'd4;
  localparam logic [2:0] REG_HSI     = 3'd5;
  localparam logic [2:0] REG_RGBW    = 3'd6;
  localparam logic [2:0] REG_IDENT   = 3'd7;

  lfr_pkg::cfg_t cfg_r;
  lfr_pkg::cfg_t cfg_nxt;
  logic          wr_en;
  logic [2:0]    idx;
  logic [7:0]    rd_byte;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign idx        = cfg_paddr[4:2];
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_DEV:     cfg_nxt.device_address    = cfg_pwdata[7:0];
        REG_BCAST:   cfg_nxt.broadcast_address = cfg_pwdata[7:0];
        REG_START:   cfg_nxt.start_byte        = cfg_pwdata[7:0];
        REG_CONFIRM: cfg_nxt.confirm_byte      = cfg_pwdata[7:0];
        REG_ESCAPE:  cfg_nxt.escape_byte       = cfg_pwdata[7:0];
        REG_HSI:     cfg_nxt.cmd_code_hsi      = cfg_pwdata[7:0];
        REG_RGBW:    cfg_nxt.cmd_code_rgbw     = cfg_pwdata[7:0];
        REG_IDENT:   cfg_nxt.cmd_code_ident    = cfg_pwdata[7:0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DEV:     rd_byte = cfg_r.device_address;
      REG_BCAST:   rd_byte = cfg_r.broadcast_address;
      REG_START:   rd_byte = cfg_r.start_byte;
      REG_CONFIRM: rd_byte = cfg_r.confirm_byte;
      REG_ESCAPE:  rd_byte = cfg_r.escape_byte;
      REG_HSI:     rd_byte = cfg_r.cmd_code_hsi;
      REG_RGBW:    rd_byte = cfg_r.cmd_code_rgbw;
      REG_IDENT:   rd_byte = cfg_r.cmd_code_ident;
      default:     rd_byte = 8'd0;
    endcase
  end

  assign cfg_prdata = {24'd0, rd_byte};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_address    <= 8'd0;
      cfg_r.broadcast_address <= 8'd255;
      cfg_r.start_byte        <= 8'd66;
      cfg_r.confirm_byte      <= 8'd35;
      cfg_r.escape_byte       <= 8'd36;
      cfg_r.cmd_code_hsi      <= 8'd1;
      cfg_r.cmd_code_rgbw     <= 8'd2;
      cfg_r.cmd_code_ident    <= 8'd3;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> src/lfr_parse.sv
module lfr_parse #(
  parameter int MIN_LEN = 4,
  parameter int MAX_LEN = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  lfr_pkg::cfg_t    cfg,
  input  logic             byte_valid,
  input  logic [7:0]       rx_byte,
  output logic             res_valid,
  output lfr_pkg::result_t res
);

  localparam int LW = $clog2(MAX_LEN + 1);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;

  logic [1:0]    phase_r, phase_nxt;
  logic          pend_r, pend_nxt;
  logic [LW-1:0] fill_r, fill_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [7:0]    crc_r, crc_nxt;
  logic [7:0]    addr_r, addr_nxt;
  logic [7:0]    cmd_r, cmd_nxt;
  logic [7:0]    opt_r [4];
  logic [7:0]    opt_nxt [4];

  logic          go;
  logic [7:0]    b;
  logic          finish;
  logic          frame_ok;
  logic [LW:0]   fill_p2;
  logic [LW:0]   fill_p1;

  assign fill_p1 = {1'b0, fill_r} + (LW+1)'(1);
  assign fill_p2 = {1'b0, fill_r} + (LW+1)'(2);

  always_comb begin
    phase_nxt = phase_r;
    pend_nxt  = pend_r;
    fill_nxt  = fill_r;
    len_nxt   = len_r;
    crc_nxt   = crc_r;
    addr_nxt  = addr_r;
    cmd_nxt   = cmd_r;
    opt_nxt   = opt_r;
    go        = 1'b0;
    b         = rx_byte;
    finish    = 1'b0;

    if (byte_valid) begin
      if (rx_byte == cfg.start_byte) begin
        pend_nxt = 1'b1;
      end else if (pend_r) begin
        pend_nxt = 1'b0;
        if (rx_byte == cfg.confirm_byte) begin
          phase_nxt = PH_LEN;
        end else if (rx_byte != cfg.escape_byte) begin
          phase_nxt = PH_IDLE;
        end else begin
          go = 1'b1;
          b  = cfg.start_byte;
        end
      end else begin
        go = 1'b1;
      end
    end

    if (go) begin
      case (phase_r)
        PH_LEN: begin
          if (b >= 8'(MIN_LEN) && b <= 8'(MAX_LEN)) begin
            len_nxt   = b[LW-1:0];
            fill_nxt  = LW'(1);
            phase_nxt = PH_BODY;
            crc_nxt   = lfr_pkg::crc8_byte(lfr_pkg::CRC_INIT, b);
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_BODY: begin
          if (fill_r < len_r) begin
            fill_nxt = fill_p1[LW-1:0];
            if (fill_r == LW'(1)) begin
              addr_nxt = b;
            end
            if (fill_r == LW'(2)) begin
              cmd_nxt = b;
            end
            for (int k = 0; k < 4; k++) begin
              if (fill_r == LW'(3 + k)) begin
                opt_nxt[k] = b;
              end
            end
            if (fill_p2 < {1'b0, len_r}) begin
              crc_nxt = lfr_pkg::crc8_byte(crc_r, b);
            end
          end
          if (fill_p1 >= {1'b0, len_r}) begin
            phase_nxt = PH_IDLE;
            finish    = 1'b1;
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  assign frame_ok = finish && (crc_r == b)
                    && (addr_r == cfg.device_address || addr_r == cfg.broadcast_address);

  always_comb begin
    res       = '0;
    res_valid = 1'b0;
    if (cmd_r == cfg.cmd_code_hsi && len_r == LW'(MIN_LEN + 3)) begin
      res.command_kind = lfr_pkg::KIND_HSI;
      res.value_a      = opt_r[0];
      res.value_b      = opt_r[1];
      res.value_c      = opt_r[2];
      res_valid        = frame_ok;
    end else if (cmd_r == cfg.cmd_code_rgbw && len_r == LW'(MIN_LEN + 4)) begin
      res.command_kind = lfr_pkg::KIND_RGBW;
      res.value_a      = opt_r[0];
      res.value_b      = opt_r[1];
      res.value_c      = opt_r[2];
      res.value_d      = opt_r[3];
      res_valid        = frame_ok;
    end else if (cmd_r == cfg.cmd_code_ident && len_r == LW'(MIN_LEN)) begin
      res.command_kind = lfr_pkg::KIND_IDENT;
      res_valid        = frame_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pend_r  <= 1'b0;
      fill_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      pend_r  <= pend_nxt;
      fill_r  <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r  <= len_nxt;
    crc_r  <= crc_nxt;
    addr_r <= addr_nxt;
    cmd_r  <= cmd_nxt;
    opt_r  <= opt_nxt;
  end

endmodule

>>> src/lfr_out.sv
module lfr_out (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             res_valid,
  input  lfr_pkg::result_t res,
  output logic             accept_ok,
  output logic             out_tvalid,
  input  logic             out_tready,
  output lfr_pkg::result_t out_res
);

  logic             out_v_r, out_v_nxt;
  logic             skid_v_r, skid_v_nxt;
  lfr_pkg::result_t out_d_r, out_d_nxt;
  lfr_pkg::result_t skid_d_r, skid_d_nxt;

  assign accept_ok  = !skid_v_r;
  assign out_tvalid = out_v_r;
  assign out_res    = out_d_r;

  always_comb begin
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (!out_v_r || out_tready) begin
      if (skid_v_r) begin
        out_v_nxt  = 1'b1;
        out_d_nxt  = skid_d_r;
        skid_v_nxt = 1'b0;
      end else begin
        out_v_nxt = res_valid;
        out_d_nxt = res;
      end
    end else if (res_valid) begin
      skid_v_nxt = 1'b1;
      skid_d_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

endmodule

>>> src/led_command_frame_receiver.sv
// Command frame receiver: takes one received serial byte per transfer on the in_ stream and
// returns one decoded command (set HSI, set RGBW or ident) on the out_ stream for every
// frame whose length, CRC-8, address and option count check out. The framing state,
// running CRC and captured header bytes update in the cycle of the transfer and the
// result lands in an output register backed by a one-entry skid stage, so in_tready
// drops only while that skid stage holds a result. Registers are set through the cfg_
// port and should be written only while no frame is in progress.
module led_command_frame_receiver #(
  parameter int MIN_LEN = 4,
  parameter int MAX_LEN = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [1:0] command_kind, [9:2] value_a, [17:10] value_b,
                                  // [25:18] value_c, [33:26] value_d, [39:34] zero
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  lfr_pkg::cfg_t    cfg;
  lfr_pkg::result_t res;
  lfr_pkg::result_t out_res;
  logic             res_valid;
  logic             accept_ok;
  logic             byte_valid;

  assign in_tready  = accept_ok;
  assign byte_valid = in_tvalid & accept_ok;
  assign out_tdata  = {(lfr_pkg::OUT_TDATA_W - $bits(lfr_pkg::result_t))'(0), out_res};

  lfr_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  lfr_parse #(
    .MIN_LEN (MIN_LEN),
    .MAX_LEN (MAX_LEN)
  ) u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .byte_valid (byte_valid),
    .rx_byte    (in_tdata),
    .res_valid  (res_valid),
    .res        (res)
  );

  lfr_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res        (res),
    .accept_ok  (accept_ok),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

endmodule

>>> bench/lcf_bench_pkg.sv
`timescale 1ns / 1ps
package lcf_bench_pkg;

  typedef enum logic [2:0] {
    REG_DEVICE_ADDRESS,
    REG_BROADCAST_ADDRESS,
    REG_START_BYTE,
    REG_CONFIRM_BYTE,
    REG_ESCAPE_BYTE,
    REG_CMD_HSI,
    REG_CMD_RGBW,
    REG_CMD_IDENT
  } cfg_reg_e;

  localparam lfr_pkg::cfg_t RESET_SETTINGS =
    '{8'd0, 8'd255, 8'd66, 8'd35, 8'd36, 8'd1, 8'd2, 8'd3};

  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] octet);
    logic [7:0] r;
    logic feedback;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      feedback = r[7] ^ octet[i];
      r = {r[6:0], 1'b0};
      if (feedback) begin
        r = r ^ lfr_pkg::CRC_POLY;
      end
    end
    return r;
  endfunction

endpackage

>>> bench/led_command_frame_checker.sv
`timescale 1ns / 1ps
module led_command_frame_checker #(
  parameter int MIN_LEN = 4,
  parameter int MAX_LEN = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [7:0]                     in_tdata,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [lfr_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [4:0]                     cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  input  logic                           cfg_pready,
  output int                             mismatches,
  output int                             commands_waiting,
  output int                             commands_seen
);
  import lfr_pkg::*;
  import lcf_bench_pkg::*;

  typedef enum logic [1:0] {PH_IDLE, PH_LENGTH, PH_COLLECT} frame_phase_e;

  cfg_t         shadow;
  frame_phase_e phase;
  logic         marker_pending;
  logic [7:0]   frame_bytes [MAX_LEN];
  int unsigned  fill;
  result_t      expected_cmds [$];

  initial begin
    mismatches = 0;
    commands_waiting = 0;
    commands_seen = 0;
  end

  task automatic note_mismatch(input string what);
    $display("%0t ns frame check: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) begin
      note_mismatch($sformatf("%s got %h want %h", name, got, want));
    end
  endtask

  task automatic decode_frame();
    int unsigned flen;
    int unsigned opts;
    logic [7:0] crc;
    result_t cmd;
    flen = frame_bytes[0];
    opts = flen - MIN_LEN;
    crc = CRC_INIT;
    for (int k = 0; k < flen - 2; k++) begin
      crc = crc8_next(crc, frame_bytes[k]);
    end
    if (crc != frame_bytes[flen - 1]) begin
      return;
    end
    if (frame_bytes[1] != shadow.device_address &&
        frame_bytes[1] != shadow.broadcast_address) begin
      return;
    end
    cmd = '0;
    if (frame_bytes[2] == shadow.cmd_code_hsi && opts == 3) begin
      cmd.command_kind = KIND_HSI;
      cmd.value_a = frame_bytes[3];
      cmd.value_b = frame_bytes[4];
      cmd.value_c = frame_bytes[5];
    end else if (frame_bytes[2] == shadow.cmd_code_rgbw && opts == 4) begin
      cmd.command_kind = KIND_RGBW;
      cmd.value_a = frame_bytes[3];
      cmd.value_b = frame_bytes[4];
      cmd.value_c = frame_bytes[5];
      cmd.value_d = frame_bytes[6];
    end else if (frame_bytes[2] == shadow.cmd_code_ident && opts == 0) begin
      cmd.command_kind = KIND_IDENT;
    end else begin
      return;
    end
    expected_cmds.push_back(cmd);
  endtask

  task automatic track_rx_byte(input logic [7:0] rx);
    logic [7:0] c;
    int unsigned flen;
    c = rx;
    if (c == shadow.start_byte) begin
      marker_pending = 1'b1;
      return;
    end
    if (marker_pending) begin
      marker_pending = 1'b0;
      if (c == shadow.confirm_byte) begin
        phase = PH_LENGTH;
        return;
      end
      if (c != shadow.escape_byte) begin
        phase = PH_IDLE;
        return;
      end
      c = shadow.start_byte;
    end
    case (phase)
      PH_LENGTH: begin
        if (c >= MIN_LEN && c <= MAX_LEN) begin
          frame_bytes[0] = c;
          fill = 1;
          phase = PH_COLLECT;
        end else begin
          phase = PH_IDLE;
        end
      end
      PH_COLLECT: begin
        flen = frame_bytes[0];
        if (fill < flen && fill < MAX_LEN) begin
          frame_bytes[fill] = c;
          fill++;
        end
        if (fill >= flen) begin
          phase = PH_IDLE;
          decode_frame();
        end
      end
      default: begin
        phase = PH_IDLE;
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    result_t got;
    result_t want;
    if (!rst_n) begin
      shadow = RESET_SETTINGS;
      phase = PH_IDLE;
      marker_pending = 1'b0;
      fill = 0;
      expected_cmds.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_reg_e'(cfg_paddr[4:2]))
          REG_DEVICE_ADDRESS:    shadow.device_address = cfg_pwdata[7:0];
          REG_BROADCAST_ADDRESS: shadow.broadcast_address = cfg_pwdata[7:0];
          REG_START_BYTE:        shadow.start_byte = cfg_pwdata[7:0];
          REG_CONFIRM_BYTE:      shadow.confirm_byte = cfg_pwdata[7:0];
          REG_ESCAPE_BYTE:       shadow.escape_byte = cfg_pwdata[7:0];
          REG_CMD_HSI:           shadow.cmd_code_hsi = cfg_pwdata[7:0];
          REG_CMD_RGBW:          shadow.cmd_code_rgbw = cfg_pwdata[7:0];
          REG_CMD_IDENT:         shadow.cmd_code_ident = cfg_pwdata[7:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        track_rx_byte(in_tdata);
      end
      if (out_tvalid && out_tready) begin
        commands_seen++;
        got = result_t'(out_tdata[$bits(result_t)-1:0]);
        if (expected_cmds.size() == 0) begin
          note_mismatch($sformatf("command with none expected: %h", out_tdata));
        end else begin
          want = expected_cmds.pop_front();
          check_field("command_kind", 8'(got.command_kind), 8'(want.command_kind));
          check_field("value_a", got.value_a, want.value_a);
          check_field("value_b", got.value_b, want.value_b);
          check_field("value_c", got.value_c, want.value_c);
          check_field("value_d", got.value_d, want.value_d);
          check_field("padding", 8'(out_tdata[OUT_TDATA_W-1:$bits(result_t)]), 8'd0);
        end
      end
    end
    commands_waiting = expected_cmds.size();
  end

endmodule

>>> bench/led_command_frame_receiver_test.sv
`timescale 1ns / 1ps
module led_command_frame_receiver_test;
  import lfr_pkg::*;
  import lcf_bench_pkg::*;

  localparam int     MIN_LEN          = 4;
  localparam int     MAX_LEN          = 16;
  localparam int     RX_BYTE_TARGET   = 650;
  localparam int     RX_BYTE_CAP      = 4000;
  localparam int     COMMAND_TARGET   = 40;
  localparam int     PHASE_BYTES      = 110;
  localparam int     QUIET_AFTER      = 540;
  localparam int     SINK_HOLD_CYCLES = 300;
  localparam int     SETTLE_CYCLES    = 8;
  localparam int     DRAIN_LIMIT      = 5000;
  localparam longint LIMIT_NS         = 20_000_000;

  typedef logic [7:0] octet_q_t [$];

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [7:0]             in_tdata;   // [7:0] rx_byte
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [1:0] command_kind, [9:2] value_a, [17:10] value_b,
                                      // [25:18] value_c, [33:26] value_d, [39:34] zero
  logic                   cfg_psel;
  logic                   cfg_penable;
  logic                   cfg_pwrite;
  logic [4:0]             cfg_paddr;
  logic [31:0]            cfg_pwdata;
  logic [31:0]            cfg_prdata;
  logic                   cfg_pready;

  int   mismatches;
  int   commands_waiting;
  int   commands_seen;
  cfg_t cur;
  int   rx_sent = 0;
  bit   idling = 1'b1;
  bit   hold_sink = 1'b0;

  always #4 clk = ~clk;

  led_command_frame_receiver #(
    .MIN_LEN(MIN_LEN),
    .MAX_LEN(MAX_LEN)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  led_command_frame_checker #(
    .MIN_LEN(MIN_LEN),
    .MAX_LEN(MAX_LEN)
  ) frame_check (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_pready(cfg_pready),
    .mismatches(mismatches),
    .commands_waiting(commands_waiting),
    .commands_seen(commands_seen)
  );

  task automatic put_byte(input logic [7:0] octet);
    if (idling && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= octet;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    rx_sent++;
  endtask

  task automatic put_literal(input logic [7:0] octet);
    if (octet == cur.start_byte) begin
      put_byte(cur.start_byte);
      put_byte(cur.escape_byte);
    end else begin
      put_byte(octet);
    end
  endtask

  task automatic send_frame(input logic [7:0] addr, input logic [7:0] code,
                            input octet_q_t opts, input bit corrupt);
    octet_q_t body;
    logic [7:0] crc;
    body = {8'(opts.size() + MIN_LEN), addr, code};
    foreach (opts[k]) body.push_back(opts[k]);
    crc = CRC_INIT;
    for (int k = 0; k < body.size() - 1; k++) begin
      crc = crc8_next(crc, body[k]);
    end
    if (corrupt) begin
      crc = crc ^ 8'(1 << $urandom_range(0, 7));
    end
    body.push_back(crc);
    put_byte(cur.start_byte);
    put_byte(cur.confirm_byte);
    foreach (body[k]) put_literal(body[k]);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [7:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= {24'd0, value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(negedge clk);
  endtask

  // drop any open frame, then wait for the block to go quiet
  task automatic finish_phase();
    logic [7:0] neutral;
    int spins;
    do begin
      neutral = 8'($urandom);
    end while (neutral == cur.start_byte || neutral == cur.confirm_byte ||
               neutral == cur.escape_byte);
    put_byte(cur.start_byte);
    put_byte(neutral);
    in_tvalid <= 1'b0;
    spins = 0;
    while (commands_waiting != 0 && spins < DRAIN_LIMIT) begin
      @(negedge clk);
      spins++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : sink_pacing
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_sink) begin
        out_tready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(negedge clk);
        hold_sink = 1'b0;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14) - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    cfg_t next_cfg;
    octet_q_t opts;
    int phase_no;
    int phase_base;
    int pick;
    int flen;
    logic [7:0] addr;
    logic [7:0] code;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'd0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    cur = RESET_SETTINGS;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // marker repeated while pending, escaped start byte in options, field extremes
    put_byte(cur.start_byte);
    opts.delete();
    send_frame(cur.device_address, cur.cmd_code_ident, opts, 1'b0);
    opts = {cur.start_byte, 8'hff, 8'h00};
    send_frame(cur.broadcast_address, cur.cmd_code_hsi, opts, 1'b0);
    opts = {8'h00, 8'hff, 8'h80, 8'h7f};
    send_frame(cur.device_address, cur.cmd_code_rgbw, opts, 1'b0);

    phase_no = 0;
    while ((rx_sent < RX_BYTE_TARGET || commands_seen < COMMAND_TARGET) &&
           rx_sent < RX_BYTE_CAP) begin
      finish_phase();
      case (phase_no)
        0: next_cfg = '{8'hff, 8'h00, 8'h00, 8'hff, 8'h80, 8'hff, 8'h00, 8'h7f};
        1: next_cfg = '{8'h00, 8'hff, 8'hff, 8'h00, 8'h7f, 8'h00, 8'hff, 8'h80};
        // shared command codes, confirm equal to escape, one address for both
        2: next_cfg = '{8'h33, 8'h33, 8'ha5, 8'h5a, 8'h5a, 8'h11, 8'h11, 8'h11};
        default: begin
          next_cfg = cfg_t'({$urandom, $urandom});
          while (next_cfg.confirm_byte == next_cfg.start_byte) begin
            next_cfg.confirm_byte = 8'($urandom);
          end
          while (next_cfg.escape_byte == next_cfg.start_byte ||
                 next_cfg.escape_byte == next_cfg.confirm_byte) begin
            next_cfg.escape_byte = 8'($urandom);
          end
        end
      endcase
      write_reg(REG_DEVICE_ADDRESS, next_cfg.device_address);
      write_reg(REG_BROADCAST_ADDRESS, next_cfg.broadcast_address);
      write_reg(REG_START_BYTE, next_cfg.start_byte);
      write_reg(REG_CONFIRM_BYTE, next_cfg.confirm_byte);
      write_reg(REG_ESCAPE_BYTE, next_cfg.escape_byte);
      write_reg(REG_CMD_HSI, next_cfg.cmd_code_hsi);
      write_reg(REG_CMD_RGBW, next_cfg.cmd_code_rgbw);
      write_reg(REG_CMD_IDENT, next_cfg.cmd_code_ident);
      cur = next_cfg;
      if (phase_no == 1) begin
        hold_sink = 1'b1;
      end

      phase_base = rx_sent;
      while (rx_sent - phase_base < PHASE_BYTES) begin
        idling = (rx_sent < QUIET_AFTER);
        pick = $urandom_range(0, 99);
        if (pick < 72) begin
          opts.delete();
          code = 8'($urandom);
          flen = $urandom_range(MIN_LEN, MAX_LEN);
          pick = $urandom_range(0, 99);
          if (pick < 30) begin
            code = cur.cmd_code_hsi;
            flen = MIN_LEN + 3;
          end else if (pick < 55) begin
            code = cur.cmd_code_rgbw;
            flen = MIN_LEN + 4;
          end else if (pick < 70) begin
            code = cur.cmd_code_ident;
            flen = MIN_LEN;
          end else if (pick < 85) begin
            case ($urandom_range(0, 2))
              0: code = cur.cmd_code_hsi;
              1: code = cur.cmd_code_rgbw;
              default: code = cur.cmd_code_ident;
            endcase
          end
          repeat (flen - MIN_LEN) begin
            opts.push_back(($urandom_range(0, 7) == 0) ? cur.start_byte : 8'($urandom));
          end
          pick = $urandom_range(0, 99);
          addr = (pick < 45) ? cur.device_address :
                 (pick < 80) ? cur.broadcast_address : 8'($urandom);
          send_frame(addr, code, opts, $urandom_range(0, 9) == 0);
        end else if (pick < 80) begin
          repeat ($urandom_range(1, 6)) put_byte(8'($urandom));
        end else if (pick < 86) begin
          put_byte(cur.start_byte);
          put_byte(8'($urandom));
        end else if (pick < 93) begin
          // cut a frame short; the next marker reopens
          flen = $urandom_range(MIN_LEN, MAX_LEN);
          put_byte(cur.start_byte);
          put_byte(cur.confirm_byte);
          put_literal(8'(flen));
          repeat ($urandom_range(0, flen - 2)) put_literal(8'($urandom));
        end else begin
          put_byte(cur.start_byte);
          put_byte(cur.confirm_byte);
          if ($urandom_range(0, 1) == 0) begin
            put_literal(8'($urandom_range(0, MIN_LEN - 1)));
          end else begin
            put_literal(8'($urandom_range(MAX_LEN + 1, 255)));
          end
        end
      end
      phase_no++;
    end

    idling = 1'b0;
    finish_phase();
    if (commands_waiting != 0) begin
      $display("%0d expected commands never arrived", commands_waiting);
    end
    if (mismatches == 0 && commands_waiting == 0) begin
      $display("led_command_frame_receiver_test: done, clean");
    end else begin
      $display("led_command_frame_receiver_test: done, errors");
    end
    $finish;
  end

  initial begin : run_limit
    #(LIMIT_NS);
    $display("led_command_frame_receiver_test: done, errors");
    $finish;
  end

endmodule

>>> files.f
src/lfr_pkg.sv
src/lfr_cfg.sv
src/lfr_parse.sv
src/lfr_out.sv
src/led_command_frame_receiver.sv
bench/lcf_bench_pkg.sv
bench/led_command_frame_checker.sv
bench/led_command_frame_receiver_test.sv
